// ===== src/kt_pkg.sv =====
// ----------------------------------------------------------------------------
// kt_pkg: shared types and constants of the Kalman tracker
// Controller states, datapath commands, register indexes and reset values.
// ----------------------------------------------------------------------------
package kt_pkg;

    localparam int unsigned W_DATA  = 32;
    localparam int unsigned W_MEAS  = 13;
    localparam int unsigned W_CIDX  = 2;

    localparam logic [W_CIDX-1:0] CFG_PROC_NOISE_POS   = 2'd0;
    localparam logic [W_CIDX-1:0] CFG_PROC_NOISE_ANGLE = 2'd1;
    localparam logic [W_CIDX-1:0] CFG_MEAS_NOISE       = 2'd2;
    localparam logic [W_CIDX-1:0] CFG_INIT_COV         = 2'd3;

    localparam logic [W_DATA-1:0] RST_PROC_NOISE_POS   = 32'd32768;
    localparam logic [W_DATA-1:0] RST_PROC_NOISE_ANGLE = 32'd5719;
    localparam logic [W_DATA-1:0] RST_MEAS_NOISE       = 32'd131072;
    localparam logic [W_DATA-1:0] RST_INIT_COV         = 32'd32768000;

    localparam logic signed [W_DATA-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [W_DATA-1:0] S32_MIN = 32'sh8000_0000;

    typedef enum logic [3:0] {
        S_IDLE, S_SETUP, S_DET, S_DCAP, S_CHK, S_NUM, S_DINIT, S_DIV,
        S_DEND, S_XMAC, S_XUPD, S_PMAC, S_PUPD, S_COMMIT, S_OUT
    } t_state;

    typedef enum logic [3:0] {
        D_NOP, D_LOAD, D_SETUP, D_MAC, D_DET, D_DIVINIT, D_DIVSTEP,
        D_DIVEND, D_XUPD, D_PUPD, D_COMMIT, D_OUT
    } t_dop;

    typedef enum logic [1:0] {
        P_DET, P_NUM, P_X, P_P
    } t_phase;

    typedef struct packed {
        t_dop        op;
        t_phase      phase;
        logic [1:0]  row;
        logic [1:0]  col;
        logic        term;
        logic        half;
        logic [4:0]  bitn;
    } t_cmd;

    typedef struct packed {
        logic det_ok;
    } t_status;

    // Index of row r, column c of the symmetric covariance in upper-triangle storage.
    function automatic logic [2:0] cidx(input logic [1:0] r, input logic [1:0] c);
        logic [1:0] lo;
        logic [1:0] hi;
        logic [2:0] res;
        lo = (r < c) ? r : c;
        hi = (r < c) ? c : r;
        unique case (lo)
            2'd0:    res = {1'b0, hi};
            2'd1:    res = 3'd2 + {1'b0, hi};
            default: res = 3'd5;
        endcase
        return res;
    endfunction

endpackage

// ===== src/kt_meas_if.sv =====
// ----------------------------------------------------------------------------
// kt_meas_if: measurement channel
// Valid/ready stream carrying one 2-D position measurement per beat.
// ----------------------------------------------------------------------------
interface kt_meas_if;
    logic        valid;
    logic        ready;
    logic [12:0] meas_x;
    logic [12:0] meas_y;

    modport source (output valid, output meas_x, output meas_y, input ready);
    modport sink   (input valid, input meas_x, input meas_y, output ready);
endinterface

// ===== src/kt_est_if.sv =====
// ----------------------------------------------------------------------------
// kt_est_if: estimate channel
// Valid/ready stream carrying one updated state estimate per beat.
// ----------------------------------------------------------------------------
interface kt_est_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] est_x;
    logic signed [31:0] est_y;
    logic signed [31:0] est_angle;
    logic               cov_saturated;

    modport source (output valid, output est_x, output est_y, output est_angle,
                    output cov_saturated, input ready);
    modport sink   (input valid, input est_x, input est_y, input est_angle,
                    input cov_saturated, output ready);
endinterface

// ===== src/kt_ctrl.sv =====
// ----------------------------------------------------------------------------
// kt_ctrl: tracker sequencer
// Steps the datapath through predict, determinant, gains, state and
// covariance update, and owns both handshakes.
// ----------------------------------------------------------------------------
module kt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    input  kt_pkg::t_status i_status,
    output kt_pkg::t_cmd    o_cmd
);

    kt_pkg::t_state r_state, n_state;
    logic [1:0] r_row, n_row;
    logic [1:0] r_col, n_col;
    logic       r_term, n_term;
    logic       r_half, n_half;
    logic [4:0] r_bit, n_bit;
    logic       r_out_valid, n_out_valid;
    logic       mac_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kt_pkg::S_IDLE;
            r_row       <= '0;
            r_col       <= '0;
            r_term      <= 1'b0;
            r_half      <= 1'b0;
            r_bit       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_term      <= n_term;
            r_half      <= n_half;
            r_bit       <= n_bit;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_term      = r_term;
        n_half      = r_half;
        n_bit       = r_bit;
        n_out_valid = r_out_valid;
        o_in_ready  = 1'b0;
        o_cmd.op    = kt_pkg::D_NOP;
        o_cmd.phase = kt_pkg::P_DET;
        o_cmd.row   = r_row;
        o_cmd.col   = r_col;
        o_cmd.term  = r_term;
        o_cmd.half  = r_half;
        o_cmd.bitn  = r_bit;
        mac_done    = r_term && r_half;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        // Every product goes through the multiplier once per half of B.
        if (r_state == kt_pkg::S_DET || r_state == kt_pkg::S_NUM ||
            r_state == kt_pkg::S_XMAC || r_state == kt_pkg::S_PMAC) begin
            n_half = ~r_half;
            if (r_half) begin
                n_term = ~r_term;
            end
        end

        unique case (r_state)
            kt_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = kt_pkg::D_LOAD;
                    n_state  = kt_pkg::S_SETUP;
                end
            end
            kt_pkg::S_SETUP: begin
                o_cmd.op = kt_pkg::D_SETUP;
                n_state  = kt_pkg::S_DET;
            end
            kt_pkg::S_DET: begin
                o_cmd.op    = kt_pkg::D_MAC;
                o_cmd.phase = kt_pkg::P_DET;
                if (mac_done) n_state = kt_pkg::S_DCAP;
            end
            kt_pkg::S_DCAP: begin
                o_cmd.op = kt_pkg::D_DET;
                n_state  = kt_pkg::S_CHK;
            end
            kt_pkg::S_CHK: begin
                n_row = '0;
                n_col = '0;
                n_state = i_status.det_ok ? kt_pkg::S_NUM : kt_pkg::S_OUT;
            end
            kt_pkg::S_NUM: begin
                o_cmd.op    = kt_pkg::D_MAC;
                o_cmd.phase = kt_pkg::P_NUM;
                if (mac_done) n_state = kt_pkg::S_DINIT;
            end
            kt_pkg::S_DINIT: begin
                o_cmd.op = kt_pkg::D_DIVINIT;
                n_bit    = 5'd31;
                n_state  = kt_pkg::S_DIV;
            end
            kt_pkg::S_DIV: begin
                o_cmd.op = kt_pkg::D_DIVSTEP;
                if (r_bit == 5'd0) n_state = kt_pkg::S_DEND;
                else n_bit = r_bit - 5'd1;
            end
            kt_pkg::S_DEND: begin
                o_cmd.op = kt_pkg::D_DIVEND;
                if (r_col == 2'd0) begin
                    n_col   = 2'd1;
                    n_state = kt_pkg::S_NUM;
                end else if (r_row != 2'd2) begin
                    n_row   = r_row + 2'd1;
                    n_col   = 2'd0;
                    n_state = kt_pkg::S_NUM;
                end else begin
                    n_row   = 2'd0;
                    n_state = kt_pkg::S_XMAC;
                end
            end
            kt_pkg::S_XMAC: begin
                o_cmd.op    = kt_pkg::D_MAC;
                o_cmd.phase = kt_pkg::P_X;
                if (mac_done) n_state = kt_pkg::S_XUPD;
            end
            kt_pkg::S_XUPD: begin
                o_cmd.op = kt_pkg::D_XUPD;
                if (r_row != 2'd2) begin
                    n_row   = r_row + 2'd1;
                    n_state = kt_pkg::S_XMAC;
                end else begin
                    n_row   = 2'd0;
                    n_col   = 2'd0;
                    n_state = kt_pkg::S_PMAC;
                end
            end
            kt_pkg::S_PMAC: begin
                o_cmd.op    = kt_pkg::D_MAC;
                o_cmd.phase = kt_pkg::P_P;
                if (mac_done) n_state = kt_pkg::S_PUPD;
            end
            kt_pkg::S_PUPD: begin
                o_cmd.op = kt_pkg::D_PUPD;
                if (r_col != 2'd2) begin
                    n_col   = r_col + 2'd1;
                    n_state = kt_pkg::S_PMAC;
                end else if (r_row != 2'd2) begin
                    n_row   = r_row + 2'd1;
                    n_col   = r_row + 2'd1;
                    n_state = kt_pkg::S_PMAC;
                end else begin
                    n_state = kt_pkg::S_COMMIT;
                end
            end
            kt_pkg::S_COMMIT: begin
                o_cmd.op = kt_pkg::D_COMMIT;
                n_state  = kt_pkg::S_OUT;
            end
            kt_pkg::S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = kt_pkg::D_OUT;
                    n_out_valid = 1'b1;
                    n_state     = kt_pkg::S_IDLE;
                end
            end
            default: n_state = kt_pkg::S_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== src/kt_datapath.sv =====
// ----------------------------------------------------------------------------
// kt_datapath: tracker arithmetic
// Filter state, configuration registers, one shared split multiplier with
// accumulator, and a radix-2 divider for the gain entries.
// ----------------------------------------------------------------------------
module kt_datapath #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  kt_pkg::t_cmd       i_cmd,
    output kt_pkg::t_status    o_status,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic [12:0]        i_meas_x,
    input  logic [12:0]        i_meas_y,
    output logic signed [31:0] o_est_x,
    output logic signed [31:0] o_est_y,
    output logic signed [31:0] o_est_angle,
    output logic               o_cov_saturated
);

    localparam int W_Y   = (FRAC_BITS + 14 > 34) ? FRAC_BITS + 14 : 34;
    localparam int W_OP  = W_Y;
    localparam int H     = W_OP / 2;
    localparam int W_PR  = W_OP + H + 1;
    localparam int W_ACC = 2 * W_OP + 2;
    localparam int W_R   = W_ACC + FRAC_BITS;
    localparam int W_DV  = W_R + 32;

    logic [31:0]        r_pnp, r_pna, r_mn;
    logic signed [31:0] r_pc [6];
    logic signed [31:0] r_np [6];
    logic signed [31:0] r_x  [3];
    logic signed [31:0] r_k  [3][2];
    logic [12:0]        r_mx, r_my;
    logic signed [W_Y-1:0]   r_y0, r_y1;
    logic signed [W_OP-1:0]  r_s00, r_s11;
    logic signed [31:0]      r_s01;
    logic signed [W_ACC-1:0] r_acc, r_det;
    logic                    r_det_ok;
    logic [W_R-1:0]          r_rem;
    logic [31:0]             r_q;
    logic                    r_neg;
    logic                    r_sat;

    logic signed [W_OP-1:0]  a_op, b_op;
    logic signed [H:0]       b_part;
    logic signed [W_PR-1:0]  prod;
    logic signed [W_ACC-1:0] pterm, acc_base;
    logic                    sub;
    logic [2:0]              e0, e1, ep, eu;
    logic [W_ACC-1:0]        mag;
    logic [W_DV-1:0]         dsh;
    logic signed [W_ACC:0]   xsum, pdif;
    logic signed [31:0]      kval;
    logic signed [33:0]      p0s, p3s, p5s;
    logic signed [31:0]      ic_sat;

    function automatic logic ovf_w(input logic signed [W_ACC:0] v);
        return !((&v[W_ACC:31]) || !(|v[W_ACC:31]));
    endfunction

    function automatic logic signed [31:0] sat_w(input logic signed [W_ACC:0] v);
        if (ovf_w(v)) return v[W_ACC] ? kt_pkg::S32_MIN : kt_pkg::S32_MAX;
        return v[31:0];
    endfunction

    function automatic logic ovf_34(input logic signed [33:0] v);
        return !((&v[33:31]) || !(|v[33:31]));
    endfunction

    function automatic logic signed [31:0] sat_34(input logic signed [33:0] v);
        if (ovf_34(v)) return v[33] ? kt_pkg::S32_MIN : kt_pkg::S32_MAX;
        return v[31:0];
    endfunction

    assign e0 = kt_pkg::cidx(i_cmd.row, 2'd0);
    assign e1 = kt_pkg::cidx(i_cmd.row, 2'd1);
    assign ep = kt_pkg::cidx({1'b0, i_cmd.term}, i_cmd.col);
    assign eu = kt_pkg::cidx(i_cmd.row, i_cmd.col);

    // Operand selection for the shared multiplier.
    always_comb begin
        a_op = '0;
        b_op = '0;
        sub  = 1'b0;
        unique case (i_cmd.phase)
            kt_pkg::P_DET: begin
                if (!i_cmd.term) begin
                    a_op = r_s00;
                    b_op = r_s11;
                end else begin
                    a_op = W_OP'(r_s01);
                    b_op = W_OP'(r_s01);
                    sub  = 1'b1;
                end
            end
            kt_pkg::P_NUM: begin
                sub = i_cmd.term;
                if (i_cmd.col[0] == 1'b0) begin
                    a_op = i_cmd.term ? W_OP'(r_pc[e1]) : W_OP'(r_pc[e0]);
                    b_op = i_cmd.term ? W_OP'(r_s01) : r_s11;
                end else begin
                    a_op = i_cmd.term ? W_OP'(r_pc[e0]) : W_OP'(r_pc[e1]);
                    b_op = i_cmd.term ? W_OP'(r_s01) : r_s00;
                end
            end
            kt_pkg::P_X: begin
                a_op = W_OP'(r_k[i_cmd.row][i_cmd.term]);
                b_op = i_cmd.term ? W_OP'(r_y1) : W_OP'(r_y0);
            end
            kt_pkg::P_P: begin
                a_op = W_OP'(r_k[i_cmd.row][i_cmd.term]);
                b_op = W_OP'(r_pc[ep]);
            end
            default: ;
        endcase
    end

    // B is split in two: the low half unsigned, the high half signed and weighted by 2^H.
    assign b_part   = i_cmd.half ? (H + 1)'($signed(b_op[W_OP-1:H]))
                                 : $signed({1'b0, b_op[H-1:0]});
    assign prod     = a_op * b_part;
    assign pterm    = i_cmd.half ? (W_ACC'(prod) <<< H) : W_ACC'(prod);
    assign acc_base = (!i_cmd.term && !i_cmd.half) ? '0 : r_acc;

    assign mag    = r_acc[W_ACC-1] ? W_ACC'(-r_acc) : W_ACC'(r_acc);
    assign dsh    = W_DV'(r_det) << i_cmd.bitn;
    assign xsum   = (W_ACC + 1)'(r_x[i_cmd.row]) + (W_ACC + 1)'(r_acc >>> FRAC_BITS);
    assign pdif   = (W_ACC + 1)'(r_pc[eu]) - (W_ACC + 1)'(r_acc >>> FRAC_BITS);
    assign kval   = r_q[31] ? (r_neg ? kt_pkg::S32_MIN : kt_pkg::S32_MAX)
                            : (r_neg ? -$signed(r_q) : $signed(r_q));
    assign p0s    = 34'(r_pc[0]) + $signed({2'b00, r_pnp});
    assign p3s    = 34'(r_pc[3]) + $signed({2'b00, r_pnp});
    assign p5s    = 34'(r_pc[5]) + $signed({2'b00, r_pna});
    assign ic_sat = i_cfg_data[31] ? kt_pkg::S32_MAX : $signed(i_cfg_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pnp <= kt_pkg::RST_PROC_NOISE_POS;
            r_pna <= kt_pkg::RST_PROC_NOISE_ANGLE;
            r_mn  <= kt_pkg::RST_MEAS_NOISE;
            for (int i = 0; i < 3; i++) r_x[i] <= '0;
            for (int e = 0; e < 6; e++) r_pc[e] <= '0;
            r_pc[0]  <= $signed(kt_pkg::RST_INIT_COV);
            r_pc[3]  <= $signed(kt_pkg::RST_INIT_COV);
            r_pc[5]  <= $signed(kt_pkg::RST_INIT_COV);
            r_sat    <= 1'b0;
            r_det_ok <= 1'b0;
        end else begin
            case (i_cmd.op)
                kt_pkg::D_LOAD: begin
                    r_mx    <= i_meas_x;
                    r_my    <= i_meas_y;
                    r_pc[0] <= sat_34(p0s);
                    r_pc[3] <= sat_34(p3s);
                    r_pc[5] <= sat_34(p5s);
                    r_sat   <= ovf_34(p0s) || ovf_34(p3s) || ovf_34(p5s);
                end
                kt_pkg::D_SETUP: begin
                    r_y0  <= (W_Y'(r_mx) << (FRAC_BITS - 1)) - W_Y'(r_x[0]);
                    r_y1  <= (W_Y'(r_my) << (FRAC_BITS - 1)) - W_Y'(r_x[1]);
                    r_s00 <= W_OP'(r_pc[0]) + $signed(W_OP'(r_mn));
                    r_s11 <= W_OP'(r_pc[3]) + $signed(W_OP'(r_mn));
                    r_s01 <= r_pc[1];
                end
                kt_pkg::D_MAC: begin
                    r_acc <= sub ? acc_base - pterm : acc_base + pterm;
                end
                kt_pkg::D_DET: begin
                    r_det    <= r_acc;
                    r_det_ok <= !r_acc[W_ACC-1] && (|r_acc);
                end
                kt_pkg::D_DIVINIT: begin
                    r_rem <= W_R'(mag) << FRAC_BITS;
                    r_neg <= r_acc[W_ACC-1];
                    r_q   <= '0;
                end
                kt_pkg::D_DIVSTEP: begin
                    if (W_DV'(r_rem) >= dsh) begin
                        r_rem           <= r_rem - W_R'(dsh);
                        r_q[i_cmd.bitn] <= 1'b1;
                    end
                end
                kt_pkg::D_DIVEND: begin
                    r_k[i_cmd.row][i_cmd.col[0]] <= kval;
                end
                kt_pkg::D_XUPD: begin
                    r_x[i_cmd.row] <= sat_w(xsum);
                end
                kt_pkg::D_PUPD: begin
                    r_np[eu] <= sat_w(pdif);
                    if (ovf_w(pdif)) r_sat <= 1'b1;
                end
                kt_pkg::D_COMMIT: begin
                    for (int e = 0; e < 6; e++) r_pc[e] <= r_np[e];
                end
                kt_pkg::D_OUT: begin
                    o_est_x         <= r_x[0];
                    o_est_y         <= r_x[1];
                    o_est_angle     <= r_x[2];
                    o_cov_saturated <= r_sat;
                end
                default: ;
            endcase

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    kt_pkg::CFG_PROC_NOISE_POS:   r_pnp <= i_cfg_data;
                    kt_pkg::CFG_PROC_NOISE_ANGLE: r_pna <= i_cfg_data;
                    kt_pkg::CFG_MEAS_NOISE:       r_mn  <= i_cfg_data;
                    kt_pkg::CFG_INIT_COV: begin
                        for (int e = 0; e < 6; e++) r_pc[e] <= '0;
                        r_pc[0] <= ic_sat;
                        r_pc[3] <= ic_sat;
                        r_pc[5] <= ic_sat;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_status.det_ok = r_det_ok;

endmodule

// ===== src/kalman_tracker_3state_2meas.sv =====
// ----------------------------------------------------------------------------
// kalman_tracker_3state_2meas: 3-state, 2-measurement Kalman tracker
// Predict and update of [x, y, theta] from position measurements in fixed point.
// ----------------------------------------------------------------------------
// Channel   Dir  Beat contents
// i_meas    in   meas_x, meas_y (half pixels)
// o_est     out  est_x, est_y, est_angle, cov_saturated
// i_cfg_*   in   register index and 32-bit value
//
// One measurement runs from acceptance through the gain computation to the result,
// or straight to the result when the innovation determinant is not positive. The
// six gain entries (one quotient bit per cycle) dominate; every product runs
// twice through a single split multiplier. Measurements are taken one at a
// time; a finished result waits in the output register and the next beat can
// be accepted meanwhile. Reset is synchronous and needs no clearing pass.
module kalman_tracker_3state_2meas #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    kt_meas_if.sink     i_meas,
    kt_est_if.source    o_est,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    kt_pkg::t_cmd    cmd;
    kt_pkg::t_status status;

    kt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_meas.valid),
        .o_in_ready  (i_meas.ready),
        .i_out_ready (o_est.ready),
        .o_out_valid (o_est.valid),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    kt_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_meas_x        (i_meas.meas_x),
        .i_meas_y        (i_meas.meas_y),
        .o_est_x         (o_est.est_x),
        .o_est_y         (o_est.est_y),
        .o_est_angle     (o_est.est_angle),
        .o_cov_saturated (o_est.cov_saturated)
    );

endmodule

// ===== src/kt_checker.sv =====
// ----------------------------------------------------------------------------
// kt_checker: port-level checks of the tracker
// Watches both channels and the reset behavior from the top-level ports.
// ----------------------------------------------------------------------------
module kt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_x
);

    // The tracker works on one measurement at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("measurement accepted while another is in work");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (i_in_ready && !i_out_valid))
        else $error("tracker not idle after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_x)))
        else $error("stalled estimate beat changed");

    // A result never appears in the cycle right after a measurement beat.
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && !i_out_valid) |=> !i_out_valid)
        else $error("estimate produced too early");

endmodule

bind kalman_tracker_3state_2meas kt_checker u_kt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_meas.valid),
    .i_in_ready  (i_meas.ready),
    .i_out_valid (o_est.valid),
    .i_out_ready (o_est.ready),
    .i_out_x     (o_est.est_x)
);
